FILE: sv/cfge_pkg.sv
// ----------------------------------------------------------------------------
// cfge_pkg
// Shared types and constants for the clip fade/gain envelope block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfge_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int POS_BITS_DEFAULT  = 32;
    localparam int CFG_WIDTH         = 32;
    localparam int CFG_IDX_BITS      = 3;
    localparam int GAIN_BITS         = 16;
    localparam int FADE_BITS         = 17;
    localparam int SEEK_BITS         = 32;
    localparam int INDEX_BITS        = 32;

    localparam logic [FADE_BITS-1:0] UNITY_Q16  = FADE_BITS'(65536);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4096);

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEEK   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_OFFSET   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_IN_LENGTH  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_OUT_LENGTH = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_GAIN       = CFG_IDX_BITS'(5);

    typedef struct packed {
        logic                          opcode;
        logic [SEEK_BITS-1:0]          seek_position;
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } cfge_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          in_window;
        logic [INDEX_BITS-1:0]         read_index;
        logic [FADE_BITS-1:0]          fade_level;
    } cfge_out_t;

    typedef struct packed {
        logic load_item;
        logic load_seek;
        logic win_step;
        logic rem_step;
        logic div_start;
        logic div_sel_out;
        logic cap_fin;
        logic cap_fout;
        logic mul_fade;
        logic mul_gain;
        logic mul_smp;
        logic sat_step;
        logic load_out;
    } cfge_cmd_t;

    typedef struct packed {
        logic seek;
        logic in_window;
        logic div_busy;
    } cfge_sts_t;

endpackage

`default_nettype wire

FILE: sv/clip_fade_gain_envelope_top.sv
// Sequence: a seek loads the position from idle; a sample outside the clip
// runs the window step, then loads the result; one inside the clip adds two
// passes of the shared fade-ratio divider plus multiply and saturate steps.
// Throughput: one request in flight; next request accepted the cycle after
// the result is loaded, even if that result is still waiting on m_ready.
// Reset: synchronous active-low aresetn clears position, registers, and valid.
// ----------------------------------------------------------------------------
// clip_fade_gain_envelope_top
// Stereo clip envelope: window test, linear fade in/out, clip gain, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_fade_gain_envelope_top #(
    parameter int POSITION_BITS = cfge_pkg::POS_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cfge_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cfge_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire cfge_pkg::cfge_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output cfge_pkg::cfge_out_t                     m_data
);
    import cfge_pkg::*;

    cfge_cmd_t cmd;
    cfge_sts_t sts;

    assign cfg_ready = 1'b1;

    cfge_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cfge_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: sv/cfge_div.sv
// ----------------------------------------------------------------------------
// cfge_div
// Restoring divider for fade ratios: floor(x * 65536 / d), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfge_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [31:0]                     dividend,
    input  wire logic [31:0]                     divisor,
    output logic                                 busy,
    output logic [cfge_pkg::FADE_BITS-1:0]       quotient
);
    import cfge_pkg::*;

    localparam int CNT_BITS = $clog2(FADE_BITS + 1);

    logic [CNT_BITS-1:0]  cnt_reg;
    logic [32:0]          rem_reg;
    logic [31:0]          div_reg;
    logic [FADE_BITS-1:0] q_reg;
    logic                 ge;
    logic [32:0]          diff;
    logic [32:0]          rem_next;

    // Valid for x <= d, so the running remainder stays below 2d.
    assign ge       = rem_reg >= {1'b0, div_reg};
    assign diff     = rem_reg - {1'b0, div_reg};
    assign rem_next = ge ? {diff[31:0], 1'b0} : {rem_reg[31:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_BITS'(FADE_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend};
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[FADE_BITS-2:0], ge};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: sv/cfge_datapath.sv
// ----------------------------------------------------------------------------
// cfge_datapath
// Config registers, timeline position, window test, fade and gain arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module cfge_datapath #(
    parameter int POSITION_BITS = cfge_pkg::POS_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr,
    input  wire logic [cfge_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cfge_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  wire cfge_pkg::cfge_in_t                 s_data,
    input  wire cfge_pkg::cfge_cmd_t                cmd,
    output cfge_pkg::cfge_sts_t                     sts,
    output cfge_pkg::cfge_out_t                     m_data
);
    import cfge_pkg::*;

    localparam int CW     = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;
    localparam int S      = SAMPLE_BITS;
    localparam int PW     = S + 32;
    localparam int QW     = PW + 1 - 28;
    localparam logic [QW-1:0] MAX_POS = QW'((64'd1 << (S - 1)) - 64'd1);
    localparam logic [QW-1:0] MAX_NEG = QW'(64'd1 << (S - 1));
    localparam logic [PW:0]   HALF    = (PW + 1)'(64'd1 << 27);

    // round half away from zero, then saturate to S bits signed
    function automatic logic [S-1:0] round_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW:0]   rnd;
        logic [QW-1:0] q;
        logic [QW-1:0] qc;
        rnd = {1'b0, p} + HALF;
        q   = rnd[PW:28];
        if (neg) begin
            qc = (q > MAX_NEG) ? MAX_NEG : q;
            return (~qc[S-1:0]) + S'(1);
        end else begin
            qc = (q > MAX_POS) ? MAX_POS : q;
            return qc[S-1:0];
        end
    endfunction

    function automatic logic [S-1:0] magnitude(input logic [S-1:0] s);
        return s[S-1] ? ((~s) + S'(1)) : s;
    endfunction

    // configuration
    logic [31:0]          window_start_reg;
    logic [31:0]          window_length_reg;
    logic [31:0]          source_offset_reg;
    logic [31:0]          ramp_in_reg;
    logic [31:0]          ramp_out_reg;
    logic [GAIN_BITS-1:0] clip_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg  <= '0;
            window_length_reg <= '0;
            source_offset_reg <= '0;
            ramp_in_reg       <= '0;
            ramp_out_reg      <= '0;
            clip_gain_reg     <= GAIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_WINDOW_START:    window_start_reg  <= cfg_data;
                REG_WINDOW_LENGTH:   window_length_reg <= cfg_data;
                REG_SOURCE_OFFSET:   source_offset_reg <= cfg_data;
                REG_RAMP_IN_LENGTH:  ramp_in_reg       <= cfg_data;
                REG_RAMP_OUT_LENGTH: ramp_out_reg      <= cfg_data;
                REG_CLIP_GAIN:       clip_gain_reg     <= cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // timeline position
    logic [POSITION_BITS-1:0] pos_reg;
    logic [CW-1:0]            seek_ext;
    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            start_ext;
    logic [CW-1:0]            end_ext;
    logic [CW-1:0]            rel_ext;
    logic                     in_win;

    assign seek_ext  = CW'(s_data.seek_position);
    assign pos_ext   = CW'(pos_reg);
    assign start_ext = CW'(window_start_reg);
    assign end_ext   = start_ext + CW'(window_length_reg);
    assign rel_ext   = pos_ext - start_ext;
    assign in_win    = (pos_ext >= start_ext) && (pos_ext < end_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.load_seek) begin
            pos_reg <= seek_ext[POSITION_BITS-1:0];
        end else if (cmd.win_step) begin
            pos_reg <= pos_reg + POSITION_BITS'(1);
        end
    end

    // divider
    logic                 div_busy;
    logic [FADE_BITS-1:0] div_q;
    logic [31:0]          rel_reg;
    logic [31:0]          rem_reg;
    logic                 fin_active;
    logic                 fout_active;

    cfge_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_out ? rem_reg : rel_reg),
        .divisor  (cmd.div_sel_out ? ramp_out_reg : ramp_in_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign fin_active  = (ramp_in_reg != '0) && (rel_reg < ramp_in_reg);
    assign fout_active = (ramp_out_reg != '0) && (rem_reg <= ramp_out_reg);

    // per-item datapath registers
    logic [S-1:0]         left_s_reg;
    logic [S-1:0]         right_s_reg;
    logic                 in_win_reg;
    logic [FADE_BITS-1:0] fin_reg;
    logic [FADE_BITS-1:0] fout_reg;
    logic [31:0]          gf_reg;
    logic [PW-1:0]        prod_l_reg;
    logic [PW-1:0]        prod_r_reg;
    logic [S-1:0]         res_left_reg;
    logic [S-1:0]         res_right_reg;
    logic [INDEX_BITS-1:0] res_index_reg;
    logic [FADE_BITS-1:0] res_fade_reg;
    cfge_out_t            out_reg;

    logic [2*FADE_BITS-1:0]         fade_prod;
    logic [FADE_BITS:0]             fade_raw;
    logic [GAIN_BITS+FADE_BITS-1:0] gf_prod;

    assign fade_prod = fin_reg * fout_reg;
    assign fade_raw  = fade_prod[2*FADE_BITS-1:16];
    assign gf_prod   = clip_gain_reg * res_fade_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            left_s_reg  <= s_data.left_in;
            right_s_reg <= s_data.right_in;
        end
        if (cmd.win_step) begin
            in_win_reg    <= in_win;
            rel_reg       <= rel_ext[31:0];
            res_left_reg  <= '0;
            res_right_reg <= '0;
            res_index_reg <= '0;
            res_fade_reg  <= '0;
        end
        if (cmd.rem_step) begin
            rem_reg       <= window_length_reg - rel_reg;
            res_index_reg <= source_offset_reg + rel_reg;
        end
        if (cmd.cap_fin) begin
            fin_reg <= fin_active ? div_q : UNITY_Q16;
        end
        if (cmd.cap_fout) begin
            fout_reg <= fout_active ? div_q : UNITY_Q16;
        end
        if (cmd.mul_fade) begin
            res_fade_reg <= (fade_raw > {1'b0, UNITY_Q16}) ? UNITY_Q16
                                                           : fade_raw[FADE_BITS-1:0];
        end
        if (cmd.mul_gain) begin
            gf_reg <= gf_prod[31:0];
        end
        if (cmd.mul_smp) begin
            prod_l_reg <= magnitude(left_s_reg) * gf_reg;
            prod_r_reg <= magnitude(right_s_reg) * gf_reg;
        end
        if (cmd.sat_step) begin
            res_left_reg  <= round_sat(prod_l_reg, left_s_reg[S-1]);
            res_right_reg <= round_sat(prod_r_reg, right_s_reg[S-1]);
        end
        if (cmd.load_out) begin
            out_reg.left_out   <= res_left_reg;
            out_reg.right_out  <= res_right_reg;
            out_reg.in_window  <= in_win_reg;
            out_reg.read_index <= res_index_reg;
            out_reg.fade_level <= res_fade_reg;
        end
    end

    assign sts.seek      = s_data.opcode == OP_SEEK;
    assign sts.in_window = in_win_reg;
    assign sts.div_busy  = div_busy;
    assign m_data        = out_reg;

endmodule

`default_nettype wire

FILE: sv/cfge_ctrl.sv
// ----------------------------------------------------------------------------
// cfge_ctrl
// Sequencer for one request at a time plus the result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cfge_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire cfge_pkg::cfge_sts_t  sts,
    output cfge_pkg::cfge_cmd_t       cmd
);
    import cfge_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WIN      = 4'd1;
    localparam logic [3:0] ST_REM      = 4'd2;
    localparam logic [3:0] ST_DIV_IN   = 4'd3;
    localparam logic [3:0] ST_DIV_OUT  = 4'd4;
    localparam logic [3:0] ST_MUL_FADE = 4'd5;
    localparam logic [3:0] ST_MUL_GAIN = 4'd6;
    localparam logic [3:0] ST_MUL_SMP  = 4'd7;
    localparam logic [3:0] ST_SAT      = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.seek) begin
                        cmd.load_seek = 1'b1;
                    end else begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_WIN;
                    end
                end
            end
            ST_WIN: begin
                cmd.win_step = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM: begin
                if (sts.in_window) begin
                    cmd.rem_step  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_IN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_IN: begin
                if (!sts.div_busy) begin
                    cmd.cap_fin     = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_out = 1'b1;
                    state_next      = ST_DIV_OUT;
                end
            end
            ST_DIV_OUT: begin
                cmd.div_sel_out = 1'b1;
                if (!sts.div_busy) begin
                    cmd.cap_fout = 1'b1;
                    state_next   = ST_MUL_FADE;
                end
            end
            ST_MUL_FADE: begin
                cmd.mul_fade = 1'b1;
                state_next   = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_MUL_SMP;
            end
            ST_MUL_SMP: begin
                cmd.mul_smp = 1'b1;
                state_next  = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat_step = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clip fade/gain envelope. It runs a directed
// pass over the clip edges and sample extremes, then random clip settings
// with seek-and-play bursts, with random idling on both sides. Every result
// is checked against an envelope computed in the bench.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cfge_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(7);
    localparam int RANDOM_REQUESTS = 600;
    localparam int PHASE_REQUESTS  = 60;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int LIMIT_CYCLES    = 600_000;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Tracks the clip registers and the timeline position, and holds the
    // envelope results still owed by the block.
    class envelope_tracker;
        cfge_out_t             owed_q[$];
        logic [SEEK_BITS-1:0]  position;
        logic [CFG_WIDTH-1:0]  window_start;
        logic [CFG_WIDTH-1:0]  window_length;
        logic [CFG_WIDTH-1:0]  source_offset;
        logic [CFG_WIDTH-1:0]  ramp_in_length;
        logic [CFG_WIDTH-1:0]  ramp_out_length;
        logic [GAIN_BITS-1:0]  clip_gain;
        int                    failures;

        function new();
            position        = '0;
            window_start    = '0;
            window_length   = '0;
            source_offset   = '0;
            ramp_in_length  = '0;
            ramp_out_length = '0;
            clip_gain       = GAIN_RESET;
            failures        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] data);
            case (idx)
                REG_WINDOW_START:    window_start    = data;
                REG_WINDOW_LENGTH:   window_length   = data;
                REG_SOURCE_OFFSET:   source_offset   = data;
                REG_RAMP_IN_LENGTH:  ramp_in_length  = data;
                REG_RAMP_OUT_LENGTH: ramp_out_length = data;
                REG_CLIP_GAIN:       clip_gain       = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // sample * gain * fade / 2^28, round half away from zero, saturate
        function logic [SAMPLE_BITS-1:0] scaled(logic signed [SAMPLE_BITS-1:0] smp,
                                                logic [FADE_BITS-1:0] fade);
            longint     wide;
            logic [63:0] mag, prod, q, pos_max;
            wide    = smp;
            mag     = (wide < 0) ? -wide : wide;
            prod    = mag * 64'(clip_gain) * 64'(fade);
            q       = (prod + (64'd1 << 27)) >> 28;
            pos_max = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
            if (wide < 0) begin
                if (q > pos_max + 64'd1)
                    q = pos_max + 64'd1;
                q = -q;
            end else if (q > pos_max) begin
                q = pos_max;
            end
            return q[SAMPLE_BITS-1:0];
        endfunction

        function void note_request(cfge_in_t req);
            logic [63:0] pos, start, stop, rel, rem, fin, fout, fade;
            cfge_out_t   res;
            if (req.opcode == OP_SEEK) begin
                position = req.seek_position;
                return;
            end
            pos   = 64'(position);
            start = 64'(window_start);
            stop  = start + 64'(window_length);   // no wrap on the window end
            res   = '0;
            if (pos >= start && pos < stop) begin
                rel  = pos - start;
                rem  = 64'(window_length) - rel;
                fin  = 64'(UNITY_Q16);
                fout = 64'(UNITY_Q16);
                if (ramp_in_length != 0 && rel < 64'(ramp_in_length))
                    fin = (rel << 16) / 64'(ramp_in_length);
                if (ramp_out_length != 0 && rem <= 64'(ramp_out_length))
                    fout = (rem << 16) / 64'(ramp_out_length);
                fade = (fin * fout) >> 16;
                if (fade > 64'(UNITY_Q16))
                    fade = 64'(UNITY_Q16);
                res.left_out   = scaled(req.left_in, fade[FADE_BITS-1:0]);
                res.right_out  = scaled(req.right_in, fade[FADE_BITS-1:0]);
                res.in_window  = 1'b1;
                res.read_index = source_offset + rel[INDEX_BITS-1:0];
                res.fade_level = fade[FADE_BITS-1:0];
            end
            owed_q.push_back(res);
            position = position + 1'b1;
        endfunction

        function void check_result(cfge_out_t got);
            cfge_out_t want;
            if (owed_q.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            want = owed_q.pop_front();
            if (got.left_out !== want.left_out) begin
                $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
                failures++;
            end
            if (got.right_out !== want.right_out) begin
                $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
                failures++;
            end
            if (got.in_window !== want.in_window) begin
                $error("in_window: expected %0d, got %0d", want.in_window, got.in_window);
                failures++;
            end
            if (got.read_index !== want.read_index) begin
                $error("read_index: expected %0h, got %0h", want.read_index, got.read_index);
                failures++;
            end
            if (got.fade_level !== want.fade_level) begin
                $error("fade_level: expected %0d, got %0d", want.fade_level, got.fade_level);
                failures++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]    cfg_data  = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    cfge_in_t                s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    cfge_out_t               m_data;

    envelope_tracker tracker;
    int              idle_pct      = 20;
    int              stall_pct     = 20;
    bit              hold_off_req  = 1'b0;
    int              requests_sent = 0;
    int              cycle_count;

    clip_fade_gain_envelope_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, or one long hold-off on request
    always begin
        @(posedge aclk);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                tracker.note_request(s_data);
            if (m_valid && m_ready)
                tracker.check_result(m_data);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // k below 5 picks an extreme, anything else a random value
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int k);
        case (k)
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3:       return '1;
            4:       return SAMPLE_BITS'(1);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic cfge_in_t sample_req(int kl, int kr);
        cfge_in_t r;
        r.opcode        = OP_SAMPLE;
        r.seek_position = $urandom;   // ignored by samples
        r.left_in       = pick_sample(kl);
        r.right_in      = pick_sample(kr);
        return r;
    endfunction

    function automatic cfge_in_t seek_req(logic [SEEK_BITS-1:0] target);
        cfge_in_t r;
        r.opcode        = OP_SEEK;
        r.seek_position = target;
        r.left_in       = SAMPLE_BITS'($urandom);
        r.right_in      = SAMPLE_BITS'($urandom);
        return r;
    endfunction

    // valid stays high after acceptance so back-to-back requests need no re-raise
    task automatic send_request(input cfge_in_t req);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_clip(input logic [CFG_WIDTH-1:0] ws, input logic [CFG_WIDTH-1:0] wl,
                                input logic [CFG_WIDTH-1:0] so, input logic [CFG_WIDTH-1:0] ri,
                                input logic [CFG_WIDTH-1:0] ro, input logic [CFG_WIDTH-1:0] gain);
        write_reg(REG_WINDOW_START, ws);
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_SOURCE_OFFSET, so);
        write_reg(REG_RAMP_IN_LENGTH, ri);
        write_reg(REG_RAMP_OUT_LENGTH, ro);
        write_reg(REG_CLIP_GAIN, gain);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, drain every owed result, then cover a trailing seek
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [CFG_WIDTH-1:0] ws, wl, so, ri, ro, gain;
        logic [SEEK_BITS-1:0] target;
        int                   phase, phase_base;

        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fade-out longer than the clip, gain high enough to saturate,
        // read index wrapping, writes to a missing register, position wrap
        write_reg(REG_UNUSED, $urandom);
        program_clip(32'd10, 32'd20, 32'hFFFF_FFF8, 32'd5, 32'd40, 32'h0000_FFFF);
        send_request(seek_req(32'd8));
        for (int i = 0; i < 10; i++)
            send_request(sample_req(i % 6, (i + 3) % 6));
        send_request(seek_req(32'd27));
        for (int i = 0; i < 4; i++)
            send_request(sample_req(i % 6, (i + 2) % 6));
        send_request(seek_req(32'hFFFF_FFFF));
        send_request(sample_req(0, 1));
        send_request(sample_req(1, 0));
        requests_sent = 0;

        phase = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            settle();
            case ($urandom_range(0, 3))
                0:       ws = $urandom;
                1:       ws = '0;
                2:       ws = 32'hFFFF_FFFF - $urandom_range(0, 20);
                default: ws = $urandom_range(0, 1000);
            endcase
            case ($urandom_range(0, 7))
                0:       wl = '0;
                1:       wl = 32'hFFFF_FFFF;
                default: wl = $urandom_range(1, 48);
            endcase
            case ($urandom_range(0, 5))
                0:       ri = '0;
                1:       ri = 32'hFFFF_FFFF;
                2:       ri = wl + $urandom_range(0, 8);
                default: ri = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 5))
                0:       ro = '0;
                1:       ro = 32'hFFFF_FFFF;
                2:       ro = wl + $urandom_range(0, 8);
                default: ro = $urandom_range(1, 24);
            endcase
            so = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
            // upper bits of the gain write are junk; only the low half counts
            case ($urandom_range(0, 4))
                0:       gain = {16'($urandom), 16'h0000};
                1:       gain = {16'($urandom), 16'hFFFF};
                2:       gain = {16'h0000, GAIN_RESET};
                default: gain = $urandom;
            endcase
            program_clip(ws, wl, so, ri, ro, gain);

            idle_pct  = (phase == 2) ? 0 : 20;
            stall_pct = (phase == 2) ? 0 : 20;
            if (phase == 4)
                hold_off_req = 1'b1;

            phase_base = requests_sent;
            while (requests_sent - phase_base < PHASE_REQUESTS
                   && requests_sent < RANDOM_REQUESTS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // seek near the clip, then play through it
                    case ($urandom_range(0, 4))
                        0, 1, 2: target = ws - $urandom_range(0, 3);
                        3:       target = ws + wl - $urandom_range(0, 3);
                        default: target = ws + $urandom;
                    endcase
                    send_request(seek_req(target));
                    repeat ($urandom_range(1, 56))
                        send_request(sample_req($urandom_range(0, 9), $urandom_range(0, 9)));
                end else if ($urandom_range(0, 1) == 0) begin
                    send_request(seek_req($urandom));
                end else begin
                    send_request(sample_req($urandom_range(0, 9), $urandom_range(0, 9)));
                end
            end
            phase++;
        end

        settle();
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
